/* hdl/flash_sector_write_staging_cache_top_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the flash sector write staging cache
// Shared property wrappers, sampled on the rising edge of clk_i.
// ---------------------------------------------------------------------------
`ifndef FLASH_SECTOR_WRITE_STAGING_CACHE_TOP_DEFINES_SVH
`define FLASH_SECTOR_WRITE_STAGING_CACHE_TOP_DEFINES_SVH

// Property checked only while out of reset.
`define FSWSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every edge, reset included.
`define FSWSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/fswsc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fswsc_pkg
// Types and constants of the flash sector write staging cache.
// ---------------------------------------------------------------------------
package fswsc_pkg;

  localparam int unsigned SECTOR_COUNT_DEF = 8192;
  localparam int unsigned SEC_W            = 13;
  localparam int unsigned SLOTS            = 8;
  localparam int unsigned SLOT_W           = 3;
  localparam int unsigned BLK_W            = SEC_W - SLOT_W;

  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_COPY  = 3'd2,
    OP_ERASE = 3'd3,
    OP_FAIL  = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FAIL,
    ST_RSCAN,
    ST_WSCAN,
    ST_WERASE,
    ST_WNEW,
    ST_MSCAN,
    ST_MCOPY,
    ST_MERASEH,
    ST_MWB,
    ST_MERASES
  } state_e;

  typedef struct packed {
    logic             command;
    logic [SEC_W-1:0] sector;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [SEC_W-1:0] src_sector;
    logic [SEC_W-1:0] dst_sector;
    logic             last;
  } out_item_t;

endpackage

/* hdl/flash_sector_write_staging_cache_top.sv */
`timescale 1ns / 1ps
// A failed request loads one fail operation; a read scans the staged slots and loads one read;
// a write appends after a scan, erases empty staging first, or merges a full or conflicting
// staging home first; result side stalls hold all of these.
// One request at a time, taken in the cycle after its last operation is loaded;
// the slot memory's one read port, stepped a slot per cycle save stalls, sets the pace.
// Reset clears the fill count, slot index, state and output valid; slots stay undefined.
// ---------------------------------------------------------------------------
// flash_sector_write_staging_cache_top
// Turns host sector reads and writes into flash read, write, copy and erase
// operations, staging writes in the last 4 KB block of the device.
// ---------------------------------------------------------------------------
module flash_sector_write_staging_cache_top #(
  parameter int unsigned SECTOR_COUNT = fswsc_pkg::SECTOR_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  fswsc_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output fswsc_pkg::out_item_t  out_item_o
);

  localparam int unsigned SW = fswsc_pkg::SEC_W;
  localparam int unsigned IW = fswsc_pkg::SLOT_W;
  localparam int unsigned BW = fswsc_pkg::BLK_W;

  // First sector of the staging block (the last 4 KB block of the device).
  localparam logic [SW-1:0] StageBase = SW'((SECTOR_COUNT / 8 - 1) * 8);
  localparam logic [SW:0]   SecLimit  = (SW+1)'(SECTOR_COUNT);
  localparam logic [BW-1:0] StageBlk  = StageBase[SW-1:IW];

  // Control state
  fswsc_pkg::state_e state_q, state_d;
  logic [IW:0]       cnt_q, cnt_d;      // staged slots in use, 0..8
  logic [IW-1:0]     idx_q, idx_d;      // slot or offset being worked on
  logic              out_valid_q, out_valid_d;

  // Working registers of the current request
  logic [SW-1:0]     addr_q, addr_d;
  logic [7:0]        cov_q, cov_d;      // offsets of the home block already staged
  logic [BW-1:0]     home_q, home_d;    // home block number during a merge
  logic              pend_q, pend_d;    // host data still to be staged after merge
  fswsc_pkg::out_item_t out_q, out_d;

  // Slot map memory: one write port, one registered read port
  logic [SW-1:0]     slot_mem_q [fswsc_pkg::SLOTS];
  logic [SW-1:0]     rdata_q;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [SW-1:0]     mem_wdata;

  logic              out_free;
  logic              idx_end;
  logic              hit;
  logic [IW:0]       cnt_last;

  function automatic fswsc_pkg::out_item_t mk_item(
    input fswsc_pkg::op_e op,
    input logic [SW-1:0]  src,
    input logic [SW-1:0]  dst,
    input logic           last
  );
    fswsc_pkg::out_item_t it;
    it.op         = op;
    it.src_sector = src;
    it.dst_sector = dst;
    it.last       = last;
    return it;
  endfunction

  assign out_free   = !out_valid_q || out_ready_i;
  assign cnt_last   = cnt_q - (IW+1)'(1);
  assign idx_end    = ({1'b0, idx_q} == cnt_last);
  assign hit        = (cnt_q != '0) && (rdata_q == addr_q);

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Write port, and a read port that always presents the slot the next
  // state will look at; forward a same-cycle write to that slot.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_we && (mem_waddr == idx_d)) begin
      rdata_q <= mem_wdata;
    end else begin
      rdata_q <= slot_mem_q[idx_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fswsc_pkg::ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    cov_q  <= cov_d;
    home_q <= home_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    addr_d      = addr_q;
    cov_d       = cov_q;
    home_d      = home_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[IW-1:0];
    mem_wdata   = addr_q;

    unique case (state_q)
      fswsc_pkg::ST_IDLE: begin
        // Take a request even while the previous result still waits.
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          addr_d = in_item_i.sector;
          idx_d  = '0;
          cov_d  = '0;
          pend_d = 1'b1;
          if (({1'b0, in_item_i.sector} + (SW+1)'(9)) > SecLimit) begin
            state_d = fswsc_pkg::ST_FAIL;
          end else if (!in_item_i.command) begin
            state_d = fswsc_pkg::ST_RSCAN;
          end else if (cnt_q == '0) begin
            state_d = fswsc_pkg::ST_WERASE;
          end else if (cnt_q[IW]) begin
            state_d = fswsc_pkg::ST_MSCAN;
          end else begin
            state_d = fswsc_pkg::ST_WSCAN;
          end
        end
      end

      fswsc_pkg::ST_FAIL: begin
        if (out_free) begin
          out_d       = mk_item(fswsc_pkg::OP_FAIL, '0, '0, 1'b1);
          out_valid_d = 1'b1;
          state_d     = fswsc_pkg::ST_IDLE;
        end
      end

      fswsc_pkg::ST_RSCAN: begin
        // Serve from the first staged slot holding the sector, else direct.
        if (hit || (cnt_q == '0) || idx_end) begin
          if (out_free) begin
            out_d = mk_item(fswsc_pkg::OP_READ,
                            hit ? {StageBlk, idx_q} : addr_q, '0, 1'b1);
            out_valid_d = 1'b1;
            state_d     = fswsc_pkg::ST_IDLE;
          end
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      fswsc_pkg::ST_WSCAN: begin
        // A repeated sector, or a sector from another block, forces a merge.
        if (rdata_q == addr_q) begin
          idx_d   = '0;
          state_d = fswsc_pkg::ST_MSCAN;
        end else if (idx_end) begin
          idx_d = '0;
          if (rdata_q[SW-1:IW] == addr_q[SW-1:IW]) begin
            state_d = fswsc_pkg::ST_WNEW;
          end else begin
            state_d = fswsc_pkg::ST_MSCAN;
          end
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      fswsc_pkg::ST_WERASE: begin
        if (out_free) begin
          out_d       = mk_item(fswsc_pkg::OP_ERASE, '0, StageBase, 1'b0);
          out_valid_d = 1'b1;
          state_d     = fswsc_pkg::ST_WNEW;
        end
      end

      fswsc_pkg::ST_WNEW: begin
        // Stage the host sector in the next free slot.
        if (out_free) begin
          out_d = mk_item(fswsc_pkg::OP_WRITE, '0, {StageBlk, cnt_q[IW-1:0]}, 1'b1);
          out_valid_d = 1'b1;
          mem_we      = 1'b1;
          mem_waddr   = cnt_q[IW-1:0];
          mem_wdata   = addr_q;
          cnt_d       = cnt_q + (IW+1)'(1);
          state_d     = fswsc_pkg::ST_IDLE;
        end
      end

      fswsc_pkg::ST_MSCAN: begin
        // Collect the staged offsets; slot 0 names the home block.
        cov_d = cov_q | (8'b1 << rdata_q[IW-1:0]);
        if (idx_q == '0) begin
          home_d = rdata_q[SW-1:IW];
        end
        if (idx_end) begin
          idx_d   = '0;
          state_d = fswsc_pkg::ST_MCOPY;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      fswsc_pkg::ST_MCOPY: begin
        // Fill the free slots with the home sectors not yet staged.
        if (!cov_q[idx_q] && !cnt_q[IW]) begin
          if (out_free) begin
            out_d = mk_item(fswsc_pkg::OP_COPY, {home_q, idx_q},
                            {StageBlk, cnt_q[IW-1:0]}, 1'b0);
            out_valid_d = 1'b1;
            mem_we      = 1'b1;
            mem_waddr   = cnt_q[IW-1:0];
            mem_wdata   = {home_q, idx_q};
            cnt_d       = cnt_q + (IW+1)'(1);
            idx_d       = idx_q + IW'(1);
            if (idx_q == '1) begin
              state_d = fswsc_pkg::ST_MERASEH;
            end
          end
        end else begin
          idx_d = idx_q + IW'(1);
          if (idx_q == '1) begin
            state_d = fswsc_pkg::ST_MERASEH;
          end
        end
      end

      fswsc_pkg::ST_MERASEH: begin
        if (out_free) begin
          out_d       = mk_item(fswsc_pkg::OP_ERASE, '0, {home_q, IW'(0)}, 1'b0);
          out_valid_d = 1'b1;
          idx_d       = '0;
          state_d     = fswsc_pkg::ST_MWB;
        end
      end

      fswsc_pkg::ST_MWB: begin
        // Write every slot back home; the host data replaces its own copy.
        if (out_free) begin
          if (rdata_q == addr_q) begin
            out_d  = mk_item(fswsc_pkg::OP_WRITE, '0,
                             {home_q, rdata_q[IW-1:0]}, 1'b0);
            pend_d = 1'b0;
          end else begin
            out_d = mk_item(fswsc_pkg::OP_COPY, {StageBlk, idx_q},
                            {home_q, rdata_q[IW-1:0]}, 1'b0);
          end
          out_valid_d = 1'b1;
          idx_d       = idx_q + IW'(1);
          if (idx_q == '1) begin
            state_d = fswsc_pkg::ST_MERASES;
          end
        end
      end

      fswsc_pkg::ST_MERASES: begin
        if (out_free) begin
          out_d       = mk_item(fswsc_pkg::OP_ERASE, '0, StageBase, !pend_q);
          out_valid_d = 1'b1;
          cnt_d       = '0;
          state_d     = pend_q ? fswsc_pkg::ST_WNEW : fswsc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = fswsc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/fswsc_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fswsc_checker
// Port-level checks of the flash sector write staging cache.
// ---------------------------------------------------------------------------
`include "flash_sector_write_staging_cache_top_defines.svh"

module fswsc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input fswsc_pkg::in_item_t  in_item_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input fswsc_pkg::out_item_t out_item_o
);

  logic single_op;

  assign single_op = (out_item_o.op == fswsc_pkg::OP_READ) ||
                     (out_item_o.op == fswsc_pkg::OP_FAIL);

  // Hold a result until it is taken.
  `FSWSC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")

  // A read or a failure is always the only, hence last, operation.
  `FSWSC_ASSERT(a_single_last, out_valid_o && single_op |-> out_item_o.last, "read or fail without last")

  // One request at a time: ready drops after an accepted item.
  `FSWSC_ASSERT(a_one_req, in_valid_i && in_ready_o |=> !in_ready_o, "second request taken")

  // No result once reset has been seen at an edge.
  `FSWSC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "result during reset")

endmodule

bind flash_sector_write_staging_cache_top fswsc_checker u_fswsc_checker (.*);
